// ===== sv/rcfe_pkg.sv =====
// ---------------------------------------------------------------------------
// rcfe_pkg
// Shared types, constants and command tables for the radar command frame
// encoder.
// ---------------------------------------------------------------------------
package rcfe_pkg;

    localparam int unsigned ModeW     = 5;
    localparam int unsigned PosW      = 5;
    localparam int unsigned PayMax    = 18;   // longest payload, three pairs
    localparam int unsigned FixedLen  = 12;   // header, length, command, footer
    localparam int unsigned HeadLen   = 4;
    localparam int unsigned CmdEnd    = 8;    // first payload position

    localparam logic [ModeW-1:0] ModeLast = 5'd16;

    typedef logic [7:0]              t_byte;
    typedef logic [PayMax-1:0][7:0]  t_pay_buf;
    typedef logic [PosW-1:0]         t_pos;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    typedef enum logic [2:0] {
        PAY_NONE,
        PAY_ONE,
        PAY_TRIPLE,
        PAY_INDEX,
        PAY_FLAG,
        PAY_PASS
    } t_pay_kind;

    typedef enum logic [ModeW-1:0] {
        MODE_ENABLE_CFG    = 5'd0,
        MODE_END_CFG       = 5'd1,
        MODE_SET_MAX_DIST  = 5'd2,
        MODE_READ_PARAMS   = 5'd3,
        MODE_ENABLE_ENG    = 5'd4,
        MODE_CLOSE_ENG     = 5'd5,
        MODE_SET_GATE_SENS = 5'd6,
        MODE_READ_FW       = 5'd7,
        MODE_SET_BAUD      = 5'd8,
        MODE_RESTORE       = 5'd9,
        MODE_RESTART       = 5'd10,
        MODE_BT            = 5'd11,
        MODE_GET_MAC       = 5'd12,
        MODE_BT_PERM       = 5'd13,
        MODE_BT_PASSWORD   = 5'd14,
        MODE_SET_RES       = 5'd15,
        MODE_QUERY_RES     = 5'd16
    } t_mode;

    // Command words all have a zero high byte, so only the low byte is kept
    function automatic t_byte f_cmd_lo(input logic [ModeW-1:0] mode);
        t_byte r;
        case (mode)
            MODE_ENABLE_CFG:    r = 8'hFF;
            MODE_END_CFG:       r = 8'hFE;
            MODE_SET_MAX_DIST:  r = 8'h60;
            MODE_READ_PARAMS:   r = 8'h61;
            MODE_ENABLE_ENG:    r = 8'h62;
            MODE_CLOSE_ENG:     r = 8'h63;
            MODE_SET_GATE_SENS: r = 8'h64;
            MODE_READ_FW:       r = 8'hA0;
            MODE_SET_BAUD:      r = 8'hA1;
            MODE_RESTORE:       r = 8'hA2;
            MODE_RESTART:       r = 8'hA3;
            MODE_BT:            r = 8'hA4;
            MODE_GET_MAC:       r = 8'hA5;
            MODE_BT_PERM:       r = 8'hA8;
            MODE_BT_PASSWORD:   r = 8'hA9;
            MODE_SET_RES:       r = 8'hAA;
            MODE_QUERY_RES:     r = 8'hAB;
            default:            r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic t_pay_kind f_pay_kind(input logic [ModeW-1:0] mode);
        t_pay_kind r;
        case (mode)
            MODE_ENABLE_CFG, MODE_GET_MAC:         r = PAY_ONE;
            MODE_SET_MAX_DIST, MODE_SET_GATE_SENS: r = PAY_TRIPLE;
            MODE_SET_BAUD, MODE_SET_RES:           r = PAY_INDEX;
            MODE_BT:                               r = PAY_FLAG;
            MODE_BT_PERM, MODE_BT_PASSWORD:        r = PAY_PASS;
            default:                               r = PAY_NONE;
        endcase
        return r;
    endfunction

    function automatic t_pos f_pay_len(input t_pay_kind kind);
        t_pos r;
        case (kind)
            PAY_ONE, PAY_INDEX, PAY_FLAG: r = 5'd2;
            PAY_TRIPLE:                   r = 5'd18;
            PAY_PASS:                     r = 5'd12;
            default:                      r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic t_byte f_head(input logic [1:0] idx);
        t_byte r;
        case (idx)
            2'd0:    r = 8'hF4;
            2'd1:    r = 8'hF3;
            2'd2:    r = 8'hF2;
            default: r = 8'hF1;
        endcase
        return r;
    endfunction

    function automatic t_byte f_foot(input logic [1:0] idx);
        t_byte r;
        case (idx)
            2'd0:    r = 8'hF8;
            2'd1:    r = 8'hF7;
            2'd2:    r = 8'hF6;
            default: r = 8'hF5;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/rcfe_byte_sel.sv =====
// ---------------------------------------------------------------------------
// rcfe_byte_sel
// Frame byte selector: picks the byte for one frame position from the
// header, length, command, payload buffer or footer, and flags the last.
// ---------------------------------------------------------------------------
module rcfe_byte_sel (
    input  rcfe_pkg::t_pos     i_pos,
    input  rcfe_pkg::t_byte    i_cmd_lo,
    input  rcfe_pkg::t_pos     i_plen,
    input  rcfe_pkg::t_pay_buf i_pay,
    output rcfe_pkg::t_byte    o_byte,
    output logic               o_last
);
    import rcfe_pkg::*;

    t_pos w_foot_start;
    t_pos w_pay_idx;
    t_pos w_foot_idx;

    assign w_foot_start = i_plen + t_pos'(CmdEnd);
    assign w_pay_idx    = i_pos - t_pos'(CmdEnd);
    assign w_foot_idx   = i_pos - w_foot_start;
    assign o_last       = (i_pos == (w_foot_start + t_pos'(3)));

    always_comb begin
        if (i_pos < t_pos'(HeadLen)) begin
            o_byte = f_head(i_pos[1:0]);
        end else if (i_pos == t_pos'(4) || i_pos == t_pos'(6)) begin
            o_byte = 8'h00;
        end else if (i_pos == t_pos'(5)) begin
            // length counts command word plus payload
            o_byte = t_byte'(i_plen) + 8'd2;
        end else if (i_pos == t_pos'(7)) begin
            o_byte = i_cmd_lo;
        end else if (i_pos < w_foot_start) begin
            o_byte = i_pay[w_pay_idx];
        end else begin
            o_byte = f_foot(w_foot_idx[1:0]);
        end
    end

endmodule

// ===== sv/radar_command_frame_encoder.sv =====
// ---------------------------------------------------------------------------
// radar_command_frame_encoder
// Serialises one radar command request into its length-prefixed UART frame,
// one byte per output word.
// ---------------------------------------------------------------------------
// A request is taken when the block is idle; the block then stalls its input
// while it emits the frame, one byte per cycle while the output is not stalled,
// through a position counter and a shared byte selector, into a single output
// register. A frame has 12 bytes plus the payload (0, 2, 12 or 18 bytes). Modes
// above 16 are accepted and produce no frame.
module radar_command_frame_encoder (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [4:0]              i_mode,
    input  logic [15:0]             i_first_word,
    input  logic [31:0]             i_first_value,
    input  logic [15:0]             i_second_word,
    input  logic [31:0]             i_second_value,
    input  logic [15:0]             i_third_word,
    input  logic [31:0]             i_third_value,
    input  logic [15:0]             i_setting_index,
    input  logic                    i_enable_flag,
    input  logic [47:0]             i_password_chars,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [7:0]              o_frame_byte,
    output logic [4:0]              o_byte_position,
    output logic                    o_last_byte
);
    import rcfe_pkg::*;

    t_state    r_state, n_state;
    t_pos      r_pos, n_pos;
    t_byte     r_cmd_lo;
    t_pos      r_plen;
    t_pay_buf  r_pay, n_pay;
    logic      r_out_valid;
    t_byte     r_byte;
    t_pos      r_bpos;
    logic      r_last;

    t_pay_kind w_kind;
    logic      w_accept;
    logic      w_load;
    t_byte     w_byte;
    logic      w_last;

    assign w_kind = f_pay_kind(i_mode);

    // payload buffer, little-endian words and dwords
    always_comb begin
        n_pay = '0;
        case (w_kind)
            PAY_ONE: begin
                n_pay[0] = 8'h01;
            end
            PAY_TRIPLE: begin
                n_pay[0]  = i_first_word[7:0];
                n_pay[1]  = i_first_word[15:8];
                n_pay[2]  = i_first_value[7:0];
                n_pay[3]  = i_first_value[15:8];
                n_pay[4]  = i_first_value[23:16];
                n_pay[5]  = i_first_value[31:24];
                n_pay[6]  = i_second_word[7:0];
                n_pay[7]  = i_second_word[15:8];
                n_pay[8]  = i_second_value[7:0];
                n_pay[9]  = i_second_value[15:8];
                n_pay[10] = i_second_value[23:16];
                n_pay[11] = i_second_value[31:24];
                n_pay[12] = i_third_word[7:0];
                n_pay[13] = i_third_word[15:8];
                n_pay[14] = i_third_value[7:0];
                n_pay[15] = i_third_value[15:8];
                n_pay[16] = i_third_value[23:16];
                n_pay[17] = i_third_value[31:24];
            end
            PAY_INDEX: begin
                n_pay[0] = i_setting_index[7:0];
                n_pay[1] = i_setting_index[15:8];
            end
            PAY_FLAG: begin
                n_pay[1] = {7'd0, i_enable_flag};
            end
            PAY_PASS: begin
                for (int i = 0; i < 6; i++) begin
                    n_pay[2*i] = i_password_chars[8*i +: 8];
                end
            end
            default: begin
                n_pay = '0;
            end
        endcase
    end

    rcfe_byte_sel u_byte_sel (
        .i_pos    (r_pos),
        .i_cmd_lo (r_cmd_lo),
        .i_plen   (r_plen),
        .i_pay    (r_pay),
        .o_byte   (w_byte),
        .o_last   (w_last)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_mode <= ModeLast) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (w_load && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_accept   = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                w_accept   = i_in_valid;
            end
            ST_SEND: begin
                w_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            n_pos = '0;
        end else if (w_load) begin
            n_pos = r_pos + t_pos'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (w_accept) begin
            r_cmd_lo <= f_cmd_lo(i_mode);
            r_plen   <= f_pay_len(w_kind);
            r_pay    <= n_pay;
        end
        if (w_load) begin
            r_byte <= w_byte;
            r_bpos <= r_pos;
            r_last <= w_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_byte    = r_byte;
    assign o_byte_position = r_bpos;
    assign o_last_byte     = r_last;

endmodule

// ===== sv/rcfe_checker.sv =====
// ---------------------------------------------------------------------------
// rcfe_checker
// Port-level checks on the frame encoder, bound to the top level.
// ---------------------------------------------------------------------------
module rcfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [4:0] i_mode,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_frame_byte,
    input logic [4:0] o_byte_position,
    input logic       o_last_byte
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_byte)
            && $stable(o_byte_position) && $stable(o_last_byte))
        else $error("output word changed while stalled");

    a_first_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_position == 5'd0 |-> o_frame_byte == 8'hF4)
        else $error("frame does not open with header byte");

    a_len_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_position == 5'd4 |-> o_frame_byte == 8'h00 && !o_last_byte)
        else $error("length high byte not zero");

    a_last_foot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte |-> o_frame_byte == 8'hF5 && o_byte_position >= 5'd11)
        else $error("last word is not the closing footer byte");

    // a taken valid command makes the encoder stall its input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_mode <= 5'd16 |=> o_in_stall)
        else $error("request taken but encoder not busy");

endmodule

bind radar_command_frame_encoder rcfe_checker u_rcfe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_mode          (i_mode),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_frame_byte    (o_frame_byte),
    .o_byte_position (o_byte_position),
    .o_last_byte     (o_last_byte)
);

// ===== tb/tb_radar_command_frame_encoder.sv =====
// ---------------------------------------------------------------------------
// tb_radar_command_frame_encoder
// Drives command requests into the frame encoder and checks every emitted
// frame byte, its position and the last-byte flag against a frame builder
// kept in a small scoreboard. The input idles and the output stalls at random.
// ---------------------------------------------------------------------------
module tb_radar_command_frame_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import rcfe_pkg::*;

    localparam int RandomItems = 115;
    localparam int HoldOffCycles = 400;
    localparam int DrainCycles = 40;
    localparam int CycleLimit = 200000;

    typedef struct {
        logic [ModeW-1:0] mode;
        logic [15:0]      first_word;
        logic [31:0]      first_value;
        logic [15:0]      second_word;
        logic [31:0]      second_value;
        logic [15:0]      third_word;
        logic [31:0]      third_value;
        logic [15:0]      setting_index;
        logic             enable_flag;
        logic [47:0]      password_chars;
    } t_cmd_req;

    typedef struct {
        t_byte data;
        t_pos  pos;
        logic  last;
    } t_frame_word;

    typedef enum {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_style;

    class frame_scoreboard;
        t_frame_word expected_bytes[$];
        t_byte       frame[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function void add_le16(logic [15:0] v);
            frame.push_back(v[7:0]);
            frame.push_back(v[15:8]);
        endfunction

        function void add_le32(logic [31:0] v);
            add_le16(v[15:0]);
            add_le16(v[31:16]);
        endfunction

        // Builds the frame a request should produce and queues its bytes
        function void note_request(t_cmd_req r);
            logic [15:0] cmd;
            logic [15:0] len;
            t_frame_word w;
            if (r.mode > ModeLast) return;   // undefined command: no frame
            case (r.mode)
                MODE_ENABLE_CFG:    cmd = 16'h00FF;
                MODE_END_CFG:       cmd = 16'h00FE;
                MODE_SET_MAX_DIST:  cmd = 16'h0060;
                MODE_READ_PARAMS:   cmd = 16'h0061;
                MODE_ENABLE_ENG:    cmd = 16'h0062;
                MODE_CLOSE_ENG:     cmd = 16'h0063;
                MODE_SET_GATE_SENS: cmd = 16'h0064;
                MODE_READ_FW:       cmd = 16'h00A0;
                MODE_SET_BAUD:      cmd = 16'h00A1;
                MODE_RESTORE:       cmd = 16'h00A2;
                MODE_RESTART:       cmd = 16'h00A3;
                MODE_BT:            cmd = 16'h00A4;
                MODE_GET_MAC:       cmd = 16'h00A5;
                MODE_BT_PERM:       cmd = 16'h00A8;
                MODE_BT_PASSWORD:   cmd = 16'h00A9;
                MODE_SET_RES:       cmd = 16'h00AA;
                default:            cmd = 16'h00AB;
            endcase
            frame.delete();
            frame.push_back(8'hF4);
            frame.push_back(8'hF3);
            frame.push_back(8'hF2);
            frame.push_back(8'hF1);
            frame.push_back(8'h00);          // length, patched below
            frame.push_back(8'h00);
            frame.push_back(cmd[15:8]);
            frame.push_back(cmd[7:0]);
            case (r.mode)
                MODE_ENABLE_CFG, MODE_GET_MAC: add_le16(16'h0001);
                MODE_SET_MAX_DIST, MODE_SET_GATE_SENS: begin
                    add_le16(r.first_word);
                    add_le32(r.first_value);
                    add_le16(r.second_word);
                    add_le32(r.second_value);
                    add_le16(r.third_word);
                    add_le32(r.third_value);
                end
                MODE_SET_BAUD, MODE_SET_RES: add_le16(r.setting_index);
                MODE_BT: add_le16(r.enable_flag ? 16'h0100 : 16'h0000);
                MODE_BT_PERM, MODE_BT_PASSWORD: begin
                    for (int i = 0; i < 6; i++)
                        add_le16({8'h00, r.password_chars[8*i +: 8]});
                end
                default: ;
            endcase
            len = 16'(frame.size() - 6);
            frame[4] = len[15:8];
            frame[5] = len[7:0];
            frame.push_back(8'hF8);
            frame.push_back(8'hF7);
            frame.push_back(8'hF6);
            frame.push_back(8'hF5);
            foreach (frame[i]) begin
                w.data = frame[i];
                w.pos  = t_pos'(i);
                w.last = (i == frame.size() - 1);
                expected_bytes.push_back(w);
            end
        endfunction

        function void check_byte(t_byte data, t_pos pos, logic last);
            t_frame_word w;
            if (expected_bytes.size() == 0) begin
                $error("unexpected output word: frame_byte %h byte_position %0d", data, pos);
                errors++;
                return;
            end
            w = expected_bytes.pop_front();
            if (data !== w.data) begin
                $error("frame_byte: expected %h, got %h", w.data, data);
                errors++;
            end
            if (pos !== w.pos) begin
                $error("byte_position: expected %0d, got %0d", w.pos, pos);
                errors++;
            end
            if (last !== w.last) begin
                $error("last_byte: expected %b, got %b", w.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [4:0]       i_mode = '0;
    logic [15:0]      i_first_word = '0;
    logic [31:0]      i_first_value = '0;
    logic [15:0]      i_second_word = '0;
    logic [31:0]      i_second_value = '0;
    logic [15:0]      i_third_word = '0;
    logic [31:0]      i_third_value = '0;
    logic [15:0]      i_setting_index = '0;
    logic             i_enable_flag = 1'b0;
    logic [47:0]      i_password_chars = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [7:0]       o_frame_byte;
    logic [4:0]       o_byte_position;
    logic             o_last_byte;

    frame_scoreboard sb = new();
    int              burst_left = 0;
    int              cycle_count = 0;

    radar_command_frame_encoder i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_first_word     (i_first_word),
        .i_first_value    (i_first_value),
        .i_second_word    (i_second_word),
        .i_second_value   (i_second_value),
        .i_third_word     (i_third_word),
        .i_third_value    (i_third_value),
        .i_setting_index  (i_setting_index),
        .i_enable_flag    (i_enable_flag),
        .i_password_chars (i_password_chars),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_byte     (o_frame_byte),
        .o_byte_position  (o_byte_position),
        .o_last_byte      (o_last_byte)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_byte(o_frame_byte, o_byte_position, o_last_byte);
    end

    // Receiver: phases of differing stall density, one long hold-off early on
    initial begin : receiver
        t_stall_style style;
        int           phase_len;
        int           phase_no;
        phase_no = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (phase_no == 2) begin
                i_out_stall <= 1'b1;
                repeat (HoldOffCycles) @(posedge i_clk);
            end else begin
                style = t_stall_style'($urandom_range(0, 3));
                phase_len = $urandom_range(10, 80);
                for (int c = 0; c < phase_len; c++) begin
                    case (style)
                        STALL_NONE:     i_out_stall <= 1'b0;
                        STALL_COIN:     i_out_stall <= 1'($urandom_range(0, 1));
                        STALL_PERIODIC: i_out_stall <= (c % 4 == 3);
                        default:        i_out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
            phase_no++;
        end
    end

    function automatic t_cmd_req flat_request(logic [ModeW-1:0] mode, logic fill);
        t_cmd_req r;
        r.mode           = mode;
        r.first_word     = {16{fill}};
        r.first_value    = {32{fill}};
        r.second_word    = {16{fill}};
        r.second_value   = {32{fill}};
        r.third_word     = {16{fill}};
        r.third_value    = {32{fill}};
        r.setting_index  = {16{fill}};
        r.enable_flag    = fill;
        r.password_chars = {48{fill}};
        return r;
    endfunction

    // Offers one request, holds it until taken, then maybe opens a gap
    task automatic send_request(input t_cmd_req r);
        i_in_valid       <= 1'b1;
        i_mode           <= r.mode;
        i_first_word     <= r.first_word;
        i_first_value    <= r.first_value;
        i_second_word    <= r.second_word;
        i_second_value   <= r.second_value;
        i_third_word     <= r.third_word;
        i_third_value    <= r.third_value;
        i_setting_index  <= r.setting_index;
        i_enable_flag    <= r.enable_flag;
        i_password_chars <= r.password_chars;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_request(r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 10);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 25)) @(posedge i_clk);
            end
        end
    endtask

    initial begin : stimulus
        t_cmd_req r;
        int       valid_sent;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every command once, fields alternately all zero and all one (gate sensitivity gets distinct values)
        for (int m = 0; m <= ModeLast; m++) begin
            r = flat_request(m[ModeW-1:0], m[0]);
            if (m == MODE_SET_GATE_SENS) begin
                r.first_word   = 16'h1234;
                r.first_value  = 32'h89AB_CDEF;
                r.second_word  = 16'h5678;
                r.second_value = 32'h0102_0304;
                r.third_word   = 16'h9ABC;
                r.third_value  = 32'hFEDC_BA98;
            end
            send_request(r);
        end
        send_request(flat_request(MODE_SET_MAX_DIST, 1'b1));
        send_request(flat_request(MODE_BT, 1'b0));
        r = flat_request(MODE_BT_PASSWORD, 1'b0);
        r.password_chars = 48'h3332_3163_6261;
        send_request(r);
        // undefined commands produce no frame
        send_request(flat_request(ModeLast + 5'd1, 1'b1));
        send_request(flat_request('1, 1'b0));

        valid_sent = 0;
        while (valid_sent < RandomItems) begin
            if ($urandom_range(0, 9) == 0)
                r.mode = ModeW'($urandom_range(ModeLast + 1, 31));
            else
                r.mode = ModeW'($urandom_range(0, ModeLast));
            r.first_word     = 16'($urandom);
            r.first_value    = $urandom;
            r.second_word    = 16'($urandom);
            r.second_value   = $urandom;
            r.third_word     = 16'($urandom);
            r.third_value    = $urandom;
            r.setting_index  = 16'($urandom);
            r.enable_flag    = 1'($urandom);
            r.password_chars = {16'($urandom), $urandom};
            if (r.mode <= ModeLast) valid_sent++;
            send_request(r);
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
